/* sv/abrf_pkg.sv */
package abrf_pkg;

	// Screen coordinate range; pixels at or past this are off screen
	localparam int COORD_LIMIT = 4096;
	localparam int COORD_W     = 12;
	localparam int PIX_W       = 32;
	localparam int CH_W        = 8;
	localparam int SHIFT_W     = 5;
	localparam int EDGE_W      = 13;
	localparam int POS_W       = 15;
	localparam logic [CH_W-1:0] CH_FULL = 8'hFF;

	// Reset values of the configuration registers
	localparam logic [CH_W-1:0]  ALPHA_RST  = 8'd255;
	localparam logic [POS_W-1:0] CHPOS_RST  = 15'd16640;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LEFT   = 3'd0,
		REG_TOP    = 3'd1,
		REG_WIDTH  = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_FILL   = 3'd4,
		REG_ALPHA  = 3'd5,
		REG_CHPOS  = 3'd6
	} cfg_reg_t;

	// Live configuration handed to the datapath
	typedef struct packed {
		logic signed [EDGE_W-1:0] left;
		logic signed [EDGE_W-1:0] top;
		logic [EDGE_W-1:0]        width;
		logic [EDGE_W-1:0]        height;
		logic [PIX_W-1:0]         fill;
		logic [CH_W-1:0]          alpha;
		logic [SHIFT_W-1:0]       red_sh;
		logic [SHIFT_W-1:0]       grn_sh;
		logic [SHIFT_W-1:0]       blu_sh;
	} cfg_t;

endpackage

/* sv/abrf_cfg_regs.sv */
module abrf_cfg_regs
	import abrf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [PIX_W-1:0]  cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// Register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left   <= '0;
			cfg_q.top    <= '0;
			cfg_q.width  <= '0;
			cfg_q.height <= '0;
			cfg_q.fill   <= '0;
			cfg_q.alpha  <= ALPHA_RST;
			cfg_q.red_sh <= CHPOS_RST[14:10];
			cfg_q.grn_sh <= CHPOS_RST[9:5];
			cfg_q.blu_sh <= CHPOS_RST[4:0];
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LEFT:   cfg_q.left   <= $signed(cfg_data[EDGE_W-1:0]);
				REG_TOP:    cfg_q.top    <= $signed(cfg_data[EDGE_W-1:0]);
				REG_WIDTH:  cfg_q.width  <= cfg_data[EDGE_W-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[EDGE_W-1:0];
				REG_FILL:   cfg_q.fill   <= cfg_data;
				REG_ALPHA:  cfg_q.alpha  <= cfg_data[CH_W-1:0];
				REG_CHPOS: begin
					cfg_q.red_sh <= cfg_data[14:10];
					cfg_q.grn_sh <= cfg_data[9:5];
					cfg_q.blu_sh <= cfg_data[4:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/abrf_rect_test.sv */
module abrf_rect_test
	import abrf_pkg::*;
(
	input  cfg_t                cfg,
	input  logic [COORD_W-1:0]  px,
	input  logic [COORD_W-1:0]  py,
	output logic                in_rect
);

	logic signed [14:0] xs, ys, x0, y0, x1, y1;
	logic               on_screen;

	// Edges in 15-bit signed space: left+width never overflows
	always_comb begin
		xs = $signed({3'b000, px});
		ys = $signed({3'b000, py});
		x0 = {{2{cfg.left[EDGE_W-1]}}, cfg.left};
		y0 = {{2{cfg.top[EDGE_W-1]}}, cfg.top};
		x1 = x0 + $signed({2'b00, cfg.width});
		y1 = y0 + $signed({2'b00, cfg.height});
		on_screen = (17'(px) < 17'(COORD_LIMIT)) && (17'(py) < 17'(COORD_LIMIT));
		in_rect = on_screen && (xs >= x0) && (xs < x1) && (ys >= y0) && (ys < y1);
	end

endmodule

/* sv/abrf_chan_mix.sv */
module abrf_chan_mix
	import abrf_pkg::*;
(
	input  logic [PIX_W-1:0]   fill,
	input  logic [PIX_W-1:0]   bg,
	input  logic [SHIFT_W-1:0] shift,
	input  logic [CH_W-1:0]    alpha,
	output logic [CH_W-1:0]    chan
);

	logic [CH_W-1:0] src, dst;
	logic [15:0]     wsum;
	logic [15:0]     quot;

	always_comb begin
		// Extract channels; bits above 31 read as zero
		src  = CH_W'(fill >> shift);
		dst  = CH_W'(bg >> shift);
		// Weighted sum, at most 255*255
		wsum = 16'(src) * 16'(alpha) + 16'(dst) * 16'(CH_FULL - alpha);
		// Divide by 255: (x + x/256 + 1)/256 is exact below 65535
		quot = wsum + 16'(wsum[15:8]) + 16'd1;
		chan = quot[15:8];
	end

endmodule

/* sv/alpha_blend_rect_fill_core.sv */
// A start transfer passes the input register and then the result register before the done strobe.
// Throughput: one pixel per clock; busy is always low.
// Stages: input register, then rectangle test, blend, divide-by-255 and pack, then result register.
// The receiver cannot stall; each result shows on done for one cycle.
// Reset (arst_n low) clears the pipeline valids and loads the register defaults.
module alpha_blend_rect_fill_core
	import abrf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [PIX_W-1:0]   background,
	output logic               done,
	output logic [PIX_W-1:0]   pixel_out,
	output logic               was_blended,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [PIX_W-1:0]   cfg_data
);

	cfg_t               cfg;
	logic               vld_s1, vld_s2;
	logic [COORD_W-1:0] px_s1, py_s1;
	logic [PIX_W-1:0]   bg_s1, pix_s2;
	logic               in_rect, blend_s2;
	logic [CH_W-1:0]    red, grn, blu;
	logic [PIX_W-1:0]   packed_px;

	assign busy = 1'b0;

	abrf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		px_s1 <= pixel_x;
		py_s1 <= pixel_y;
		bg_s1 <= background;
	end

	abrf_rect_test u_rect (
		.cfg     (cfg),
		.px      (px_s1),
		.py      (py_s1),
		.in_rect (in_rect)
	);

	// Per-channel blend
	abrf_chan_mix u_red (
		.fill (cfg.fill), .bg (bg_s1), .shift (cfg.red_sh),
		.alpha (cfg.alpha), .chan (red)
	);
	abrf_chan_mix u_grn (
		.fill (cfg.fill), .bg (bg_s1), .shift (cfg.grn_sh),
		.alpha (cfg.alpha), .chan (grn)
	);
	abrf_chan_mix u_blu (
		.fill (cfg.fill), .bg (bg_s1), .shift (cfg.blu_sh),
		.alpha (cfg.alpha), .chan (blu)
	);

	// Repack by OR; bits shifted past 31 drop off
	assign packed_px = (PIX_W'(red) << cfg.red_sh) | (PIX_W'(grn) << cfg.grn_sh)
		| (PIX_W'(blu) << cfg.blu_sh);

	// Result register
	always_ff @(posedge clk) begin
		pix_s2   <= in_rect ? packed_px : bg_s1;
		blend_s2 <= in_rect;
	end

	assign done        = vld_s2;
	assign pixel_out   = pix_s2;
	assign was_blended = blend_s2 && vld_s2;

	// Every accepted pixel yields a result once it has passed the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("result missing two cycles after start");

	// No result without a matching transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without an accepted pixel");

	// Pass-through pixels come back untouched
	a_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !was_blended) |-> pixel_out == $past(background, 2))
		else $error("unblended pixel altered");

	// Outside the rectangle never reports a blend
	a_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !in_rect) |-> ##1 !was_blended)
		else $error("blend flagged outside rectangle");

endmodule

/* tb/abrf_checker.sv */
module abrf_checker
	import abrf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [PIX_W-1:0]   background,
	input  logic               done,
	input  logic [PIX_W-1:0]   pixel_out,
	input  logic               was_blended,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [PIX_W-1:0]   cfg_data,
	output int                 fails,
	output int                 pending,
	output int                 blended
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             blended;
	} blend_res_t;

	// Shadow copy of the register file, updated from observed writes
	logic signed [EDGE_W-1:0] left_q;
	logic signed [EDGE_W-1:0] top_q;
	logic [EDGE_W-1:0]        width_q;
	logic [EDGE_W-1:0]        height_q;
	logic [PIX_W-1:0]         fill_q;
	logic [CH_W-1:0]          alpha_q;
	logic [POS_W-1:0]         chpos_q;

	blend_res_t expected_px[$];
	int n_bad;
	int n_blend;

	// Shifts past 24 read zeros above bit 31 on extract and drop them on pack
	function automatic logic [CH_W-1:0] take_ch(logic [PIX_W-1:0] w, logic [SHIFT_W-1:0] sh);
		return CH_W'(w >> sh);
	endfunction

	function automatic logic [PIX_W-1:0] put_ch(logic [CH_W-1:0] c, logic [SHIFT_W-1:0] sh);
		return PIX_W'(c) << sh;
	endfunction

	// Weighted average of two channels, truncated
	function automatic logic [CH_W-1:0] mix_ch(logic [CH_W-1:0] src, logic [CH_W-1:0] dst,
		logic [CH_W-1:0] a);
		int unsigned s, d, k, full;
		s = src;
		d = dst;
		k = a;
		full = CH_FULL;
		return CH_W'((s * k + d * (full - k)) / full);
	endfunction

	function automatic blend_res_t blend_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
		logic [PIX_W-1:0] bg);
		int px, py, x0, y0, x1, y1;
		logic [SHIFT_W-1:0] rs, gs, bs;
		blend_res_t r;
		px = x;
		py = y;
		x0 = left_q;
		y0 = top_q;
		x1 = x0 + int'(width_q);
		y1 = y0 + int'(height_q);
		rs = chpos_q[3*SHIFT_W-1 -: SHIFT_W];
		gs = chpos_q[2*SHIFT_W-1 -: SHIFT_W];
		bs = chpos_q[SHIFT_W-1:0];
		if (px >= COORD_LIMIT || py >= COORD_LIMIT || px < x0 || px >= x1 ||
			py < y0 || py >= y1) begin
			r.pix = bg;
			r.blended = 1'b0;
		end else begin
			// channels OR together, so overlapping positions combine
			r.pix = put_ch(mix_ch(take_ch(fill_q, rs), take_ch(bg, rs), alpha_q), rs) |
				put_ch(mix_ch(take_ch(fill_q, gs), take_ch(bg, gs), alpha_q), gs) |
				put_ch(mix_ch(take_ch(fill_q, bs), take_ch(bg, bs), alpha_q), bs);
			r.blended = 1'b1;
		end
		return r;
	endfunction

	// Compare results, queue predictions, track register writes
	always @(posedge clk or negedge arst_n) begin
		blend_res_t want;
		if (!arst_n) begin
			left_q   = '0;
			top_q    = '0;
			width_q  = '0;
			height_q = '0;
			fill_q   = '0;
			alpha_q  = ALPHA_RST;
			chpos_q  = CHPOS_RST;
			expected_px.delete();
			n_bad   = 0;
			n_blend = 0;
		end else begin
			if (done) begin
				if (expected_px.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: result with no pixel outstanding: pixel_out %h was_blended %b",
							$time, pixel_out, was_blended);
				end else begin
					want = expected_px.pop_front();
					if (pixel_out !== want.pix || was_blended !== want.blended) begin
						n_bad++;
						if (n_bad <= 10)
							$display("%0t: pixel_out %h (expected %h), was_blended %b (expected %b)",
								$time, pixel_out, want.pix, was_blended, want.blended);
					end
					if (want.blended)
						n_blend++;
				end
			end
			if (start && !busy)
				expected_px.push_back(blend_pixel(pixel_x, pixel_y, background));
			if (cfg_we) begin
				case (cfg_index)
					REG_LEFT:   left_q   = cfg_data[EDGE_W-1:0];
					REG_TOP:    top_q    = cfg_data[EDGE_W-1:0];
					REG_WIDTH:  width_q  = cfg_data[EDGE_W-1:0];
					REG_HEIGHT: height_q = cfg_data[EDGE_W-1:0];
					REG_FILL:   fill_q   = cfg_data;
					REG_ALPHA:  alpha_q  = cfg_data[CH_W-1:0];
					REG_CHPOS:  chpos_q  = cfg_data[POS_W-1:0];
					default: ;
				endcase
			end
		end
		fails   <= n_bad;
		pending <= expected_px.size();
		blended <= n_blend;
	end

endmodule

/* tb/tb_top.sv */
module tb_top;
	import abrf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_SPARE = 3'd7;	// not mapped, writes must be ignored
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [PIX_W-1:0]   background;
	logic               done;
	logic [PIX_W-1:0]   pixel_out;
	logic               was_blended;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [PIX_W-1:0]   cfg_data;

	int fails;
	int pending;
	int blended;
	int idle_pct;
	int n_pixels;
	int n_settings;
	int stall_cnt;
	int idle_plan[3] = '{21, 82, 0};

	// Rectangle currently programmed, used to aim coordinates
	int rect_x0, rect_y0, rect_w, rect_h;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	alpha_blend_rect_fill_core dut (.*);

	abrf_checker u_checker (.*);

	// Watchdog: cycles without any transfer, result or register write
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
	end

	initial begin
		wait (stall_cnt >= STALL_LIMIT);
		$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// Register write; bits above the register width carry junk
	task automatic set_reg(input logic [2:0] idx, input logic [31:0] value, input int bits);
		logic [31:0] junk;
		junk = $urandom;
		cfg_index <= idx;
		if (bits >= 32)
			cfg_data <= value;
		else
			cfg_data <= (junk << bits) | (value & ((32'd1 << bits) - 32'd1));
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_all(input int x0, input int y0, input int w, input int h,
		input logic [31:0] fill, input logic [7:0] a, input logic [14:0] pos);
		rect_x0 = x0;
		rect_y0 = y0;
		rect_w  = w;
		rect_h  = h;
		set_reg(REG_LEFT, 32'(x0), EDGE_W);
		set_reg(REG_TOP, 32'(y0), EDGE_W);
		set_reg(REG_WIDTH, 32'(w), EDGE_W);
		set_reg(REG_HEIGHT, 32'(h), EDGE_W);
		set_reg(REG_FILL, fill, PIX_W);
		set_reg(REG_ALPHA, 32'(a), CH_W);
		set_reg(REG_CHPOS, 32'(pos), POS_W);
		n_settings++;
	endtask

	// One pixel transfer, with random idle cycles ahead of it
	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input logic [31:0] bg);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		pixel_x    <= x;
		pixel_y    <= y;
		background <= bg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		n_pixels++;
	endtask

	// Stop sending and let every outstanding result arrive
	task automatic quiesce;
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Coordinate in or just around the rectangle span most of the time, anywhere otherwise
	function automatic logic [11:0] aim(input int lo, input int ext);
		int v;
		if ($urandom_range(9) < 3)
			return 12'($urandom_range(4095));
		v = lo - 2 + int'($urandom_range(ext + 3));
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	task automatic random_setting;
		int x0, y0, w, h;
		logic [7:0] a;
		logic [14:0] pos;
		case ($urandom_range(7))
			0: begin
				x0 = int'($urandom_range(8191)) - 4096;
				y0 = int'($urandom_range(8191)) - 4096;
				w  = $urandom_range(8191);
				h  = $urandom_range(8191);
			end
			1: begin
				// empty rectangle
				x0 = int'($urandom_range(4095));
				y0 = int'($urandom_range(4095));
				w  = ($urandom_range(1) == 0) ? 0 : $urandom_range(8191);
				h  = (w == 0) ? $urandom_range(8191) : 0;
			end
			default: begin
				x0 = int'($urandom_range(3300)) - 200;
				y0 = int'($urandom_range(3300)) - 200;
				w  = $urandom_range(900, 1);
				h  = $urandom_range(900, 1);
			end
		endcase
		case ($urandom_range(5))
			0: a = 8'd0;
			1: a = 8'd255;
			default: a = 8'($urandom);
		endcase
		if ($urandom_range(4) == 0)
			pos = 15'($urandom);
		else
			pos = {5'($urandom_range(24)), 5'($urandom_range(24)), 5'($urandom_range(24))};
		program_all(x0, y0, w, h, $urandom, a, pos);
		if ($urandom_range(3) == 0)
			set_reg(REG_SPARE, $urandom, 32);
	endtask

	initial begin
		start      = 1'b0;
		pixel_x    = '0;
		pixel_y    = '0;
		background = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_LEFT;
		cfg_data   = '0;
		arst_n     = 1'b0;
		idle_pct   = 0;
		n_pixels   = 0;
		n_settings = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults: empty rectangle, everything passes through
		send_pixel(12'd0, 12'd0, 32'h0000_0000);
		send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
		quiesce;

		// widest rectangle, opaque fill at default positions
		program_all(-4096, -4096, 8191, 8191, 32'h1234_5678, 8'd255, CHPOS_RST);
		send_pixel(12'd0, 12'd0, 32'hA5A5_A5A5);
		send_pixel(12'd4094, 12'd4094, 32'hFFFF_FFFF);
		send_pixel(12'd4095, 12'd0, 32'h0BAD_F00D);
		send_pixel(12'd0, 12'd4095, 32'h8000_0001);
		quiesce;

		// one-row strip edges, zero alpha, shifts of 24 and above
		program_all(100, 200, 10, 1, 32'hFFFF_FFFF, 8'd0, {5'd31, 5'd25, 5'd24});
		send_pixel(12'd99, 12'd200, 32'hFEDC_BA98);
		send_pixel(12'd100, 12'd200, 32'hFEDC_BA98);
		send_pixel(12'd109, 12'd200, 32'h7654_3210);
		send_pixel(12'd110, 12'd200, 32'h7654_3210);
		send_pixel(12'd100, 12'd199, 32'hFFFF_FFFF);
		send_pixel(12'd100, 12'd201, 32'hFFFF_FFFF);
		quiesce;

		// single pixel at the far corner, all channels on top of each other
		program_all(4095, 4095, 1, 1, 32'hDEAD_BEEF, 8'd128, {5'd3, 5'd3, 5'd3});
		send_pixel(12'd4095, 12'd4095, 32'h0F0F_0F0F);
		send_pixel(12'd4094, 12'd4095, 32'h0F0F_0F0F);
		quiesce;

		// rectangle ending left of the screen; unmapped index must not disturb it
		program_all(-4096, 0, 100, 8191, 32'h00FF_00FF, 8'd77, 15'd0);
		set_reg(REG_SPARE, 32'hFFFF_FFFF, 32);
		send_pixel(12'd0, 12'd0, 32'h1357_9BDF);
		send_pixel(12'd0, 12'd100, 32'h2468_ACE0);
		quiesce;

		// random settings, sender idling light, heavy, then not at all
		foreach (idle_plan[p]) begin
			idle_pct = idle_plan[p];
			repeat (4) begin
				random_setting();
				repeat (96)
					send_pixel(aim(rect_x0, rect_w), aim(rect_y0, rect_h), $urandom);
				quiesce;
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d pixel transfers, %0d of them blended, over %0d register settings.",
			n_pixels, blended, n_settings);
		$display("Rectangle edges, zero and full alpha, overlapping and wide channel shifts exercised.");
		if (fails == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* alpha_blend_rect_fill_core.f */
sv/abrf_pkg.sv
sv/abrf_cfg_regs.sv
sv/abrf_rect_test.sv
sv/abrf_chan_mix.sv
sv/alpha_blend_rect_fill_core.sv
tb/abrf_checker.sv
tb/tb_top.sv
